@@ sv/uri_component_splitter_top_defines.svh @@
`ifndef URI_COMPONENT_SPLITTER_TOP_DEFINES_SVH
`define URI_COMPONENT_SPLITTER_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define UCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define UCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/ucs_pkg.sv @@
package ucs_pkg;

  typedef enum logic [2:0] {
    SEC_PROTOCOL = 3'd0,
    SEC_HOST     = 3'd1,
    SEC_PATH     = 3'd2,
    SEC_QUERY    = 3'd3,
    SEC_FRAGMENT = 3'd4
  } sec_t;

  typedef enum logic [2:0] {
    KIND_PROTOCOL = 3'd0,
    KIND_HOST     = 3'd1,
    KIND_PATH     = 3'd2,
    KIND_QUERY    = 3'd3,
    KIND_FRAGMENT = 3'd4,
    KIND_SUMMARY  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int MAG_W   = 31;
  localparam int PORT_W  = 32;
  localparam int GRP_N   = 3;
  localparam int TDATA_W = 48;
  localparam int TUSER_W = 3;

  localparam logic [MAG_W-1:0] PORT_MAX = '1;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       ch;
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             given;
    logic             defl;
    logic             valid;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [1:0]        cnt;
    item_t [GRP_N-1:0] items;
  } grp_t;

  function automatic item_t char_item(kind_t k, logic [7:0] c);
    item_t it;
    it      = '0;
    it.kind = k;
    it.ch   = c;
    return it;
  endfunction

endpackage

@@ sv/ucs_parse.sv @@
`include "uri_component_splitter_top_defines.svh"

module ucs_parse (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output ucs_pkg::grp_t grp
);
  import ucs_pkg::*;

  sec_t             section, section_next;
  logic [1:0]       held, held_next;
  logic [MAG_W-1:0] accum, accum_next;
  logic             neg, neg_next;
  phase_t           phase, phase_next;
  logic             seen, seen_next;
  logic             path_has, path_has_next;

  logic             is_ws, is_sign, is_digit;
  logic [1:0]       pre, nch;
  logic [MAG_W+3:0] acc_x10;
  logic [MAG_W-1:0] acc_sat;
  item_t            summ;

  always_ff @(posedge clk) begin
    if (rst) begin
      section  <= SEC_PROTOCOL;
      held     <= '0;
      accum    <= '0;
      neg      <= 1'b0;
      phase    <= PH_SPACE;
      seen     <= 1'b0;
      path_has <= 1'b0;
    end else begin
      section  <= section_next;
      held     <= held_next;
      accum    <= accum_next;
      neg      <= neg_next;
      phase    <= phase_next;
      seen     <= seen_next;
      path_has <= path_has_next;
    end
  end

  assign is_ws    = (in_byte == CH_SPACE) || ((in_byte >= CH_TAB) && (in_byte <= CH_CR));
  assign is_sign  = (in_byte == CH_PLUS) || (in_byte == CH_MINUS);
  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign acc_x10  = ({4'b0, accum} << 3) + ({4'b0, accum} << 1)
                  + {{(MAG_W){1'b0}}, in_byte[3:0]};
  assign acc_sat  = (acc_x10 > {4'b0, PORT_MAX}) ? PORT_MAX : acc_x10[MAG_W-1:0];

  always_comb begin
    section_next  = section;
    held_next     = held;
    accum_next    = accum;
    neg_next      = neg;
    phase_next    = phase;
    seen_next     = seen;
    path_has_next = path_has;
    pre           = 2'd0;
    nch           = 2'd0;
    summ          = '0;
    grp           = '0;
    if (fire) begin
      unique case (section)
        SEC_PROTOCOL: begin
          if ((held == 2'd1) && (in_byte == CH_SLASH)) begin
            held_next = 2'd2;
          end else if ((held == 2'd2) && (in_byte == CH_SLASH)) begin
            held_next    = 2'd0;
            section_next = SEC_HOST;
          end else begin
            // release held bytes, then treat this byte afresh
            pre = (held == 2'd2) ? 2'd2 : ((held == 2'd1) ? 2'd1 : 2'd0);
            grp.items[0] = char_item(KIND_PROTOCOL, CH_COLON);
            grp.items[1] = char_item(KIND_PROTOCOL, CH_SLASH);
            if (in_byte == CH_COLON) begin
              held_next = 2'd1;
              nch       = pre;
            end else begin
              held_next      = 2'd0;
              grp.items[pre] = char_item(KIND_PROTOCOL, in_byte);
              nch            = pre + 2'd1;
            end
          end
        end
        SEC_HOST: begin
          if (in_byte == CH_SLASH) begin
            section_next  = SEC_PATH;
            path_has_next = 1'b1;
            grp.items[0]  = char_item(KIND_PATH, in_byte);
            nch           = 2'd1;
          end else if (in_byte == CH_QUEST) begin
            section_next = SEC_QUERY;
          end else if (in_byte == CH_HASH) begin
            section_next = SEC_FRAGMENT;
          end else if (seen) begin
            unique case (phase)
              PH_SPACE: begin
                if (is_ws) begin
                  phase_next = PH_SPACE;
                end else if (is_sign) begin
                  neg_next   = (in_byte == CH_MINUS);
                  phase_next = PH_DIGITS;
                end else if (is_digit) begin
                  accum_next = acc_sat;
                  phase_next = PH_DIGITS;
                end else begin
                  phase_next = PH_DONE;
                end
              end
              PH_DIGITS: begin
                if (is_digit) begin
                  accum_next = acc_sat;
                end else begin
                  phase_next = PH_DONE;
                end
              end
              default: phase_next = phase;
            endcase
          end else if (in_byte == CH_COLON) begin
            seen_next = 1'b1;
          end else begin
            grp.items[0] = char_item(KIND_HOST, in_byte);
            nch          = 2'd1;
          end
        end
        SEC_PATH: begin
          if (in_byte == CH_QUEST) begin
            section_next = SEC_QUERY;
          end else if (in_byte == CH_HASH) begin
            section_next = SEC_FRAGMENT;
          end else begin
            path_has_next = 1'b1;
            grp.items[0]  = char_item(KIND_PATH, in_byte);
            nch           = 2'd1;
          end
        end
        SEC_QUERY: begin
          if (in_byte == CH_HASH) begin
            section_next = SEC_FRAGMENT;
          end else begin
            grp.items[0] = char_item(KIND_QUERY, in_byte);
            nch          = 2'd1;
          end
        end
        default: begin
          section_next = SEC_FRAGMENT;
          grp.items[0] = char_item(KIND_FRAGMENT, in_byte);
          nch          = 2'd1;
        end
      endcase

      grp.cnt = nch;
      if (in_last) begin
        summ.kind = KIND_SUMMARY;
        summ.last = 1'b1;
        if (section_next == SEC_PROTOCOL) begin
          // no separator: drop pending characters, report invalid
          grp.items[0] = summ;
          grp.cnt      = 2'd1;
        end else begin
          summ.mag       = accum_next;
          summ.neg       = neg_next;
          summ.given     = seen_next;
          summ.defl      = !path_has_next;
          summ.valid     = 1'b1;
          grp.items[nch] = summ;
          grp.cnt        = nch + 2'd1;
        end
        section_next  = SEC_PROTOCOL;
        held_next     = '0;
        accum_next    = '0;
        neg_next      = 1'b0;
        phase_next    = PH_SPACE;
        seen_next     = 1'b0;
        path_has_next = 1'b0;
      end
    end
  end

  `UCS_ASSERT_NOW(a_held_in_protocol, held != 2'd0, section == SEC_PROTOCOL,
                  "held bytes outside protocol section")
  `UCS_ASSERT_NOW(a_phase_needs_colon, phase != PH_SPACE, seen,
                  "port decoding advanced without a colon")
  `UCS_ASSERT_NOW(a_accum_needs_colon, accum != '0, seen,
                  "port value without a colon")
  `UCS_ASSERT_NEXT(a_clear_after_last, fire && in_last,
                   (section == SEC_PROTOCOL) && (held == 2'd0) && !seen && !path_has,
                   "parser not cleared after final byte")

endmodule

@@ sv/ucs_emit.sv @@
`include "uri_component_splitter_top_defines.svh"

module ucs_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  ucs_pkg::grp_t               grp,
  output logic                        free,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // char_out[7:0], port_value[39:8], port_given[40], path_defaulted[41],
  // uri_valid[42], zero fill
  output logic [ucs_pkg::TDATA_W-1:0] m_tdata,
  // kind[2:0]
  output logic [ucs_pkg::TUSER_W-1:0] m_tuser,
  output logic                        m_tlast
);
  import ucs_pkg::*;

  logic [1:0]        cnt;
  item_t [GRP_N-1:0] items;
  item_t             head;
  logic [PORT_W-1:0] mag_ext, port_value;
  logic              take;

  assign take     = m_tvalid && m_tready;
  assign free     = (cnt == 2'd0) || ((cnt == 2'd1) && m_tready);
  assign m_tvalid = (cnt != 2'd0);
  assign head     = items[0];
  assign mag_ext  = {1'b0, head.mag};

  always_comb begin
    if (head.kind != KIND_SUMMARY) begin
      port_value = '0;
    end else if (!head.given) begin
      port_value = '1;
    end else if (head.neg) begin
      port_value = '0 - mag_ext;
    end else begin
      port_value = mag_ext;
    end
  end

  assign m_tdata = {{(TDATA_W - 43){1'b0}}, head.valid, head.defl, head.given,
                    port_value, head.ch};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= grp.cnt;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      items <= grp.items;
    end else if (take) begin
      items <= {items[GRP_N-1], items[GRP_N-1:1]};
    end
  end

  `UCS_ASSERT_NOW(a_last_is_summary, m_tvalid && m_tlast, m_tuser == KIND_SUMMARY,
                  "tlast on a character item")
  `UCS_ASSERT_NOW(a_summary_is_last, m_tvalid && (m_tuser == KIND_SUMMARY), m_tlast,
                  "summary without tlast")
  `UCS_ASSERT_NEXT(a_load_shows, load && (grp.cnt != 2'd0), m_tvalid,
                   "loaded results not presented")

endmodule

@@ sv/uri_component_splitter_top.sv @@
// URI splitter: one URI byte per input item (tlast marks the final byte);
// each byte comes back as a protocol, host, path, query or fragment item in
// tuser, delimiters (bar the slash that opens a path) and port text are
// dropped, and the final byte adds a summary item (tlast high) with the
// decoded port and flags. A byte is registered at the input, then parsed and
// loaded into the result buffer once that is empty or its last item is taken;
// a byte yields at most three results (held ":/" released by a protocol byte,
// or a character plus summary), sent one per cycle while m_tready is high.
module uri_component_splitter_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // byte_in[7:0]
  input  logic [7:0]                  s_tdata,
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // char_out[7:0], port_value[39:8], port_given[40], path_defaulted[41],
  // uri_valid[42], zero fill
  output logic [ucs_pkg::TDATA_W-1:0] m_tdata,
  // kind[2:0]
  output logic [ucs_pkg::TUSER_W-1:0] m_tuser,
  output logic                        m_tlast
);
  import ucs_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       free, load;
  grp_t       grp;

  assign load     = in_valid && free;
  assign s_tready = !in_valid || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (free) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  ucs_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .fire    (load),
    .in_byte (in_byte),
    .in_last (in_last),
    .grp     (grp)
  );

  ucs_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .grp      (grp),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import ucs_pkg::*;

  localparam logic [PORT_W-1:0] PORT_UNDEF = '1;
  localparam int                WATCHDOG   = 3000;
  localparam int                HOLD_CYC   = 250;
  localparam int                ITEMS      = 420;
  localparam int                CALM_AFTER = 360;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        ch;
    logic [PORT_W-1:0] port;
    logic              given;
    logic              defl;
    logic              valid;
    logic              last;
  } part_t;

  typedef struct packed {
    logic [7:0]        c;
    logic              eol;
    logic              typed;
    logic [PORT_W-1:0] port;
    logic              given;
    logic              defl;
    logic              valid;
  } dir_row_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata  = '0;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;
  logic [TUSER_W-1:0]  m_tuser;
  logic                m_tlast;

  logic                calm     = 1'b0;
  int                  items_sent;
  int                  mismatches;
  int                  quiet_cycles;
  int                  parts_seen;
  int                  hold_left;
  int                  stall_left;
  bit                  hold_done;

  part_t               expected_parts[$];

  sec_t                sec;
  logic [1:0]          held;
  logic [PORT_W-1:0]   acc;
  logic                neg;
  phase_t              phase;
  logic                port_seen;
  logic                path_seen;

  dir_row_t dir_rows [25] = '{
    '{8'h61,    1'b1, 1'b1, 32'hffffffff, 1'b0, 1'b0, 1'b0},
    '{CH_COLON, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{CH_SLASH, 1'b1, 1'b1, 32'hffffffff, 1'b0, 1'b0, 1'b0},
    '{CH_COLON, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{CH_SLASH, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{CH_COLON, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{CH_SLASH, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{CH_SLASH, 1'b1, 1'b1, 32'hffffffff, 1'b0, 1'b1, 1'b1},
    '{CH_COLON, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{CH_SLASH, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{CH_SLASH, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{CH_COLON, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{CH_SPACE, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{CH_MINUS, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{8'h37,    1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{CH_HASH,  1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{CH_QUEST, 1'b1, 1'b1, 32'hfffffff9, 1'b1, 1'b1, 1'b1},
    '{CH_COLON, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{CH_SLASH, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{CH_SLASH, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{8'h00,    1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{CH_SLASH, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{8'hff,    1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{CH_QUEST, 1'b0, 1'b0, 32'h0,        1'b0, 1'b0, 1'b0},
    '{CH_HASH,  1'b1, 1'b1, 32'hffffffff, 1'b0, 1'b0, 1'b1}
  };

  uri_component_splitter_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic part_t summary_part(logic [PORT_W-1:0] port, logic given,
                                         logic defl, logic valid);
    part_t p;
    p       = '0;
    p.kind  = KIND_SUMMARY;
    p.port  = port;
    p.given = given;
    p.defl  = defl;
    p.valid = valid;
    p.last  = 1'b1;
    return p;
  endfunction

  task automatic clear_split();
    sec       = SEC_PROTOCOL;
    held      = 2'd0;
    acc       = '0;
    neg       = 1'b0;
    phase     = PH_SPACE;
    port_seen = 1'b0;
    path_seen = 1'b0;
  endtask

  task automatic push_char(kind_t k, logic [7:0] c);
    part_t p;
    p      = '0;
    p.kind = k;
    p.ch   = c;
    expected_parts.push_back(p);
  endtask

  task automatic protocol_byte(logic [7:0] c);
    if (c == CH_COLON) held = 2'd1;
    else push_char(KIND_PROTOCOL, c);
  endtask

  task automatic split_byte(input logic [7:0] c, input logic eol);
    int                base;
    logic              skip;
    logic [7:0]        digit;
    logic [63:0]       grown;
    logic [PORT_W-1:0] port;
    base = expected_parts.size();
    skip = 1'b0;
    case (sec)
      SEC_PROTOCOL: begin
        if (held == 2'd1) begin
          if (c == CH_SLASH) begin
            held = 2'd2;
          end else begin
            held = 2'd0;
            push_char(KIND_PROTOCOL, CH_COLON);
            protocol_byte(c);
          end
        end else if (held == 2'd2) begin
          held = 2'd0;
          if (c == CH_SLASH) begin
            sec = SEC_HOST;
          end else begin
            push_char(KIND_PROTOCOL, CH_COLON);
            push_char(KIND_PROTOCOL, CH_SLASH);
            protocol_byte(c);
          end
        end else begin
          protocol_byte(c);
        end
      end
      SEC_HOST: begin
        if (c == CH_SLASH) begin
          sec       = SEC_PATH;
          path_seen = 1'b1;
          push_char(KIND_PATH, c);
        end else if (c == CH_QUEST) begin
          sec = SEC_QUERY;
        end else if (c == CH_HASH) begin
          sec = SEC_FRAGMENT;
        end else if (port_seen) begin
          if (phase == PH_SPACE) begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
              skip = 1'b1;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
              neg   = (c == CH_MINUS);
              phase = PH_DIGITS;
              skip  = 1'b1;
            end else begin
              phase = PH_DIGITS;
            end
          end
          if (!skip && phase == PH_DIGITS) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
              digit = c - CH_ZERO;
              grown = {32'd0, acc} * 64'd10 + {56'd0, digit};
              acc   = (grown > {33'd0, PORT_MAX}) ? {1'b0, PORT_MAX} : grown[31:0];
            end else begin
              phase = PH_DONE;
            end
          end
        end else if (c == CH_COLON) begin
          port_seen = 1'b1;
        end else begin
          push_char(KIND_HOST, c);
        end
      end
      SEC_PATH: begin
        if (c == CH_QUEST) begin
          sec = SEC_QUERY;
        end else if (c == CH_HASH) begin
          sec = SEC_FRAGMENT;
        end else begin
          path_seen = 1'b1;
          push_char(KIND_PATH, c);
        end
      end
      SEC_QUERY: begin
        if (c == CH_HASH) sec = SEC_FRAGMENT;
        else push_char(KIND_QUERY, c);
      end
      default: begin
        sec = SEC_FRAGMENT;
        push_char(KIND_FRAGMENT, c);
      end
    endcase
    if (eol) begin
      if (sec == SEC_PROTOCOL) begin
        // drop anything this byte released
        while (expected_parts.size() > base) void'(expected_parts.pop_back());
        expected_parts.push_back(summary_part(PORT_UNDEF, 1'b0, 1'b0, 1'b0));
      end else begin
        port = port_seen ? (neg ? (32'd0 - acc) : acc) : PORT_UNDEF;
        expected_parts.push_back(summary_part(port, port_seen, !path_seen, 1'b1));
      end
      clear_split();
    end
  endtask

  task automatic send_byte(input logic [7:0] c, input logic eol);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eol;
    do @(posedge clk); while (!s_tready);
    split_byte(c, eol);
    items_sent++;
    if (items_sent >= CALM_AFTER) calm <= 1'b1;
  endtask

  function automatic logic [7:0] plain_byte(logic [7:0] b);
    if (b == CH_COLON || b == CH_SLASH || b == CH_QUEST || b == CH_HASH)
      return b ^ 8'h40;
    return b;
  endfunction

  task automatic send_random_uri();
    logic [7:0] uri[$];
    int         mode;
    int         n;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      n = $urandom_range(1, 10);
      repeat (n) uri.push_back(8'($urandom));
    end else if (mode == 1) begin
      n = $urandom_range(0, 4);
      repeat (n) uri.push_back(plain_byte(8'($urandom)));
      uri.push_back(CH_COLON);
      if ($urandom_range(0, 1)) uri.push_back(CH_SLASH);
      n = $urandom_range(0, 4);
      repeat (n) uri.push_back(8'($urandom));
    end else begin
      n = $urandom_range(0, 5);
      repeat (n) uri.push_back(plain_byte(8'($urandom)));
      // false starts of the separator
      if ($urandom_range(0, 3) == 0) begin
        uri.push_back(CH_COLON);
        if ($urandom_range(0, 1)) uri.push_back(CH_SLASH);
        uri.push_back(plain_byte(8'($urandom)));
      end
      uri.push_back(CH_COLON);
      uri.push_back(CH_SLASH);
      uri.push_back(CH_SLASH);
      n = $urandom_range(0, 6);
      repeat (n) uri.push_back(plain_byte(8'($urandom)));
      if ($urandom_range(0, 1)) begin
        uri.push_back(CH_COLON);
        n = $urandom_range(0, 2);
        repeat (n) uri.push_back($urandom_range(0, 2) == 0 ? CH_SPACE :
                                 8'($urandom_range(CH_TAB, CH_CR)));
        case ($urandom_range(0, 2))
          0: uri.push_back(CH_PLUS);
          1: uri.push_back(CH_MINUS);
          default: ;
        endcase
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 5);
        repeat (n) uri.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        if ($urandom_range(0, 2) == 0) begin
          n = $urandom_range(1, 3);
          repeat (n) uri.push_back(8'($urandom));
        end
      end
      if ($urandom_range(0, 1)) begin
        uri.push_back(CH_SLASH);
        n = $urandom_range(0, 5);
        repeat (n) uri.push_back(plain_byte(8'($urandom)));
      end
      if ($urandom_range(0, 2) == 0) begin
        uri.push_back(CH_QUEST);
        n = $urandom_range(0, 4);
        repeat (n) uri.push_back(plain_byte(8'($urandom)));
      end
      if ($urandom_range(0, 2) == 0) begin
        uri.push_back(CH_HASH);
        n = $urandom_range(0, 4);
        repeat (n) uri.push_back(8'($urandom));
      end
    end
    foreach (uri[i]) send_byte(uri[i], i == uri.size() - 1);
  endtask

  task automatic check_part();
    part_t              want;
    logic [TDATA_W-1:0] want_data;
    if (expected_parts.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected item: kind %0d tdata %h last %b", m_tuser, m_tdata, m_tlast);
      mismatches++;
    end else begin
      want      = expected_parts.pop_front();
      want_data = {5'd0, want.valid, want.defl, want.given, want.port, want.ch};
      if (m_tuser !== want.kind || m_tdata !== want_data || m_tlast !== want.last) begin
        if (mismatches < 10)
          $display("mismatch: want kind %0d tdata %h last %b, got kind %0d tdata %h last %b",
                   want.kind, want_data, want.last, m_tuser, m_tdata, m_tlast);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      check_part();
      parts_seen++;
    end
    if (!hold_done && parts_seen >= 150) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYC;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!rst && !calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rst;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG);
    $display("tb: failure");
    $finish;
  end

  initial begin
    clear_split();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].c, dir_rows[i].eol);
      if (dir_rows[i].typed) begin
        part_t s;
        s = expected_parts.pop_back();
        s = summary_part(dir_rows[i].port, dir_rows[i].given, dir_rows[i].defl,
                         dir_rows[i].valid);
        expected_parts.push_back(s);
      end
    end
    while (items_sent < ITEMS) send_random_uri();
    s_tvalid <= 1'b0;
    while (expected_parts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/ucs_pkg.sv
sv/ucs_parse.sv
sv/ucs_emit.sv
sv/uri_component_splitter_top.sv
dv/tb_top.sv
